### hdl/lru_value_tracker_defines.svh
// assertion helpers shared by the tracker modules
`ifndef LRU_VALUE_TRACKER_DEFINES_SVH
`define LRU_VALUE_TRACKER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LVT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lvt check failed");

// next-cycle implication, checked outside reset
`define LVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lvt check failed");

`endif

### hdl/lvt_pkg.sv
package lvt_pkg;

    localparam int CAP_W   = 5;
    localparam int FIELD_W = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_APPLY
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_key;
        logic search;
        logic apply;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic error;
    } t_stat;

endpackage

### hdl/lvt_ctrl.sv
`include "lru_value_tracker_defines.svh"

module lvt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_out_stall,
    input  lvt_pkg::t_stat i_stat,
    output lvt_pkg::t_cmd o_cmd
);
    import lvt_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   can_load;
    logic   accept;

    // result slot free, or being emptied this cycle
    assign can_load = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_SEARCH;
            end
            ST_SEARCH: n_state = ST_APPLY;
            ST_APPLY: begin
                if (can_load) n_state = i_valid ? ST_SEARCH : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall  = 1'b1;
        o_cmd    = '0;
        unique case (r_state)
            ST_IDLE:   o_stall = 1'b0;
            ST_SEARCH: o_cmd.search = 1'b1;
            ST_APPLY: begin
                o_stall     = !can_load;
                o_cmd.apply = can_load;
            end
            default: o_stall = 1'b1;
        endcase
        accept         = i_valid && !o_stall;
        o_cmd.load_key = accept;
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.apply) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

    `LVT_ASSERT_NEXT(a_search_then_apply, i_clk, i_rst_n, r_state == ST_SEARCH, r_state == ST_APPLY)
    `LVT_ASSERT_NEXT(a_accept_starts_search, i_clk, i_rst_n, accept, r_state == ST_SEARCH)
    `LVT_ASSERT_NEXT(a_blocked_apply_waits, i_clk, i_rst_n, (r_state == ST_APPLY) && !can_load, (r_state == ST_APPLY) && r_out_valid)
    `LVT_ASSERT_NOW(a_hit_never_errors, i_clk, i_rst_n, r_state == ST_APPLY, !(i_stat.hit && i_stat.error))

endmodule

### hdl/lvt_datapath.sv
`include "lru_value_tracker_defines.svh"

module lvt_datapath #(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lvt_pkg::CAP_W-1:0]     i_cfg_wdata,
    input  lvt_pkg::t_cmd                 i_cmd,
    output lvt_pkg::t_stat                o_stat,
    input  logic [lvt_pkg::FIELD_W-1:0]   i_key_value,
    output logic                          o_status,
    output logic                          o_hit,
    output logic                          o_evicted_valid,
    output logic [lvt_pkg::FIELD_W-1:0]   o_evicted_value,
    output logic [lvt_pkg::CAP_W-1:0]     o_occupancy
);
    import lvt_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int EXT_W = (VALUE_BITS > FIELD_W) ? VALUE_BITS : FIELD_W;

    // recency lanes, lane 0 most recent
    logic [VALUE_BITS-1:0] r_entry [DEPTH];
    logic [VALUE_BITS-1:0] n_entry [DEPTH];
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [CAP_W-1:0]      r_capacity;

    logic [VALUE_BITS-1:0] r_key;
    logic [EXT_W-1:0]      key_ext;
    logic [EXT_W-1:0]      ev_ext;

    // search stage results
    logic                  r_found;
    logic [IDX_W-1:0]      r_pos;
    logic [VALUE_BITS-1:0] r_last;
    logic [DEPTH-1:0]      match;
    logic                  found;
    logic [IDX_W-1:0]      pos;
    logic [CNT_W-1:0]      last_idx;

    // apply stage decision
    logic [CMP_W-1:0]      cap_eff;
    logic [CMP_W-1:0]      cap_ext;
    logic [CMP_W-1:0]      cnt_ext;
    logic                  is_error;
    logic                  is_evict;
    logic                  do_write;
    logic [IDX_W-1:0]      upto;

    // result register
    logic                  r_status;
    logic                  r_hit;
    logic                  r_ev_valid;
    logic [FIELD_W-1:0]    r_ev_value;
    logic [CAP_W-1:0]      r_occ;

    always_comb begin
        key_ext = '0;
        key_ext[FIELD_W-1:0] = i_key_value;
    end

    // parallel compare against the occupied lanes
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            match[i] = (r_entry[i] == r_key) && (CNT_W'(i) < r_count);
        end
        found = |match;
        pos   = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (match[i]) pos = IDX_W'(i);
        end
        last_idx = r_count - CNT_W'(1);
    end

    always_comb begin
        cap_ext  = CMP_W'(r_capacity);
        cap_eff  = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
        cnt_ext  = CMP_W'(r_count);
        is_error = !r_found && (cap_eff == '0);
        is_evict = !r_found && !is_error && (cnt_ext >= cap_eff);
        do_write = i_cmd.apply && !is_error;
        n_count  = r_count;
        if (r_found) begin
            upto = r_pos;
        end else if (is_evict) begin
            upto = last_idx[IDX_W-1:0];
        end else begin
            upto = r_count[IDX_W-1:0];
            if (i_cmd.apply && !is_error) n_count = r_count + CNT_W'(1);
        end
        for (int i = 0; i < DEPTH; i++) begin
            n_entry[i] = r_entry[i];
            if (do_write && (IDX_W'(i) <= upto)) begin
                n_entry[i] = (i == 0) ? r_key : r_entry[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_comb begin
        ev_ext = '0;
        ev_ext[VALUE_BITS-1:0] = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_capacity <= CAP_RESET;
        end else begin
            r_count <= n_count;
            if (i_cfg_we) r_capacity <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_entry[i] <= n_entry[i];
        end
        if (i_cmd.load_key) r_key <= key_ext[VALUE_BITS-1:0];
        if (i_cmd.search) begin
            r_found <= found;
            r_pos   <= pos;
            if (r_count != '0) r_last <= r_entry[last_idx[IDX_W-1:0]];
        end
        if (i_cmd.apply) begin
            r_status   <= is_error;
            r_hit      <= r_found;
            r_ev_valid <= is_evict;
            r_ev_value <= is_evict ? ev_ext[FIELD_W-1:0] : '0;
            r_occ      <= CAP_W'(n_count);
        end
    end

    assign o_stat.hit      = r_found;
    assign o_stat.error    = is_error;
    assign o_status        = r_status;
    assign o_hit           = r_hit;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_value = r_ev_value;
    assign o_occupancy     = r_occ;

    `LVT_ASSERT_NOW(a_count_bounded, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `LVT_ASSERT_NEXT(a_evict_keeps_count, i_clk, i_rst_n, i_cmd.apply && !r_found, $stable(r_count) || (r_count == $past(r_count) + CNT_W'(1)))

endmodule

### hdl/lru_value_tracker.sv
// lru_value_tracker: least-recently-used replacement list of up to DEPTH distinct values,
// most recent first. Each input transaction carries one value; it is compared against all
// held values at once, then the list shifts so the value lands at the front (a hit moves it,
// a miss inserts it, a miss at capacity evicts the least recent value and reports it; a miss
// at zero capacity just reports an error). One result transaction follows every input
// transaction, which passes a compare state over all lanes, then a shift state that updates
// the list and loads the result register. A new transaction is taken during the previous
// shift while the result side keeps taking; a stalled result blocks the next shift. The
// capacity register resets to 16, saturates at DEPTH and should only be written while idle.
module lru_value_tracker #(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // capacity register
    input  logic                               i_cfg_we,
    input  logic [lvt_pkg::CAP_W-1:0]          i_cfg_wdata,
    // input transaction
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [lvt_pkg::FIELD_W-1:0] i_key_value,
    // result transaction
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_status,
    output logic                               o_hit,
    output logic                               o_evicted_valid,
    output logic signed [lvt_pkg::FIELD_W-1:0] o_evicted_value,
    output logic [lvt_pkg::CAP_W-1:0]          o_occupancy
);
    import lvt_pkg::*;

    t_cmd               cmd;
    t_stat              stat;
    logic [FIELD_W-1:0] ev_value;

    // sequencing: idle, compare, shift and result load
    lvt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_out_stall (i_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // recency lanes, comparators, count and result register
    lvt_datapath #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_key_value     (i_key_value),
        .o_status        (o_status),
        .o_hit           (o_hit),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_value (ev_value),
        .o_occupancy     (o_occupancy)
    );

    // payload is a raw bit pattern, reinterpret as two's complement
    assign o_evicted_value = signed'(ev_value);

endmodule

### bench/testbench.sv
module testbench;

    localparam int DEPTH       = 16;
    localparam int KEY_W       = lvt_pkg::FIELD_W;
    localparam int CAP_W       = lvt_pkg::CAP_W;
    localparam int MAX_WAIT    = 11;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SHOWN_FAULTS = 10;

    // one result transaction as the tracker reports it
    typedef struct packed {
        logic             status;
        logic             hit;
        logic             evicted_valid;
        logic [KEY_W-1:0] evicted_value;
        logic [CAP_W-1:0] occupancy;
    } t_lru_result;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CAP_W-1:0]        i_cfg_wdata;
    logic                    i_valid;
    logic                    o_stall;
    logic signed [KEY_W-1:0] i_key_value;
    logic                    o_valid;
    logic                    i_stall;
    logic                    o_status;
    logic                    o_hit;
    logic                    o_evicted_valid;
    logic signed [KEY_W-1:0] o_evicted_value;
    logic [CAP_W-1:0]        o_occupancy;

    lru_value_tracker #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (KEY_W)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_key_value     (i_key_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_hit           (o_hit),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_value (o_evicted_value),
        .o_occupancy     (o_occupancy)
    );

    // clock, period 8
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow copy of the tracker: recency list, most recent at index 0
    logic [KEY_W-1:0] held_keys [DEPTH];
    int unsigned      held_count;
    logic [CAP_W-1:0] capacity_shadow;

    t_lru_result pending_results [$];
    int unsigned fault_count;
    int unsigned cycle_count;

    // long receiver hold-off, owned by its own process
    logic hold_armed;
    logic hold_active;

    // quiet stretches with no idling, one counter per side
    int unsigned send_quiet;
    int unsigned sink_quiet;

    // shift the list down by one up to position upto and place key at the front
    function automatic void move_to_front(int unsigned upto, logic [KEY_W-1:0] key);
        for (int i = upto; i > 0; i--)
            held_keys[i] = held_keys[i-1];
        held_keys[0] = key;
    endfunction

    // apply one touch to the shadow list and return the result it should give
    function automatic t_lru_result touch_key(logic [KEY_W-1:0] key);
        t_lru_result res;
        int unsigned eff_cap;
        int          pos;
        res     = '0;
        pos     = -1;
        // capacity saturates at the list depth
        eff_cap = (capacity_shadow > DEPTH) ? DEPTH : capacity_shadow;
        for (int i = 0; i < held_count; i++)
            if (pos < 0 && held_keys[i] == key)
                pos = i;
        if (pos >= 0) begin
            // a hit always moves to the front, even at zero capacity, and never evicts
            res.hit = 1'b1;
            move_to_front(pos, key);
        end else if (eff_cap == 0) begin
            // miss with zero capacity: error, list untouched
            res.status = 1'b1;
        end else if (held_count >= eff_cap) begin
            // full, or capacity lowered below occupancy: drop exactly the least recent
            res.evicted_valid = 1'b1;
            res.evicted_value = held_keys[held_count-1];
            move_to_front(held_count - 1, key);
        end else begin
            move_to_front(held_count, key);
            held_count++;
        end
        res.occupancy = held_count[CAP_W-1:0];
        return res;
    endfunction

    // cycles to wait before the next transaction on one side
    function automatic int unsigned draw_wait(inout int unsigned quiet);
        if (quiet != 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            quiet = $urandom_range(5, 30);
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL lru_value_tracker");
            $finish;
        end
    end

    // monitor: predict on each accepted input, check each accepted result
    always @(posedge i_clk) begin
        t_lru_result want;
        t_lru_result got;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = '{o_status, o_hit, o_evicted_valid, o_evicted_value, o_occupancy};
                if (pending_results.size() == 0) begin
                    fault_count++;
                    if (fault_count <= SHOWN_FAULTS) begin
                        $write("result with nothing expected: ");
                        $display("status %0d hit %0d ev %0d/%h occ %0d",
                                 got.status, got.hit, got.evicted_valid,
                                 got.evicted_value, got.occupancy);
                    end
                end else begin
                    want = pending_results.pop_front();
                    if (got.status != want.status || got.hit != want.hit
                        || got.evicted_valid != want.evicted_valid
                        || got.evicted_value != want.evicted_value
                        || got.occupancy != want.occupancy) begin
                        fault_count++;
                        if (fault_count <= SHOWN_FAULTS) begin
                            $write("mismatch: expected status %0d hit %0d ev %0d/%h occ %0d, ",
                                   want.status, want.hit, want.evicted_valid,
                                   want.evicted_value, want.occupancy);
                            $display("got status %0d hit %0d ev %0d/%h occ %0d",
                                     got.status, got.hit, got.evicted_valid,
                                     got.evicted_value, got.occupancy);
                        end
                    end
                end
            end
            if (i_valid && !o_stall)
                pending_results.push_back(touch_key(i_key_value));
        end
    end

    // result sink: random pause per result, then take it unless the long hold is on
    initial begin : result_sink
        int unsigned pause;
        i_stall    = 1'b0;
        sink_quiet = 0;
        forever begin
            pause = draw_wait(sink_quiet);
            repeat (pause) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
            end
            do begin
                @(negedge i_clk);
                i_stall <= hold_active;
                @(posedge i_clk);
            end while (!(o_valid && !i_stall));
        end
    end

    // long hold-off counted here so the sender keeps offering and the block backs up
    initial begin : long_hold
        hold_active = 1'b0;
        wait (hold_armed);
        @(posedge i_clk);
        hold_active = 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        hold_active = 1'b0;
    end

    // offer one input transaction after gap idle cycles, return once it is taken
    task automatic send_key(input logic [KEY_W-1:0] key, input int unsigned gap);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_key_value <= key;
        do @(posedge i_clk); while (o_stall);
    endtask

    // stop offering and wait until every expected result has come back
    task automatic drain;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // capacity write, only ever issued with the block idle
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        capacity_shadow = value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= CAP_W'($urandom());
    endtask

    // directed: field extremes, hits at front and back, zero capacity,
    // capacity below occupancy, capacity above depth with fill and eviction
    task automatic test_directed;
        write_capacity(5'd16);
        send_key(32'h8000_0000, draw_wait(send_quiet));
        send_key(32'h7fff_ffff, draw_wait(send_quiet));
        send_key(32'h0000_0000, draw_wait(send_quiet));
        send_key(32'hffff_ffff, draw_wait(send_quiet));
        send_key(32'h0000_0001, draw_wait(send_quiet));
        send_key(32'h0000_0001, draw_wait(send_quiet));   // hit at the front
        send_key(32'h8000_0000, draw_wait(send_quiet));   // hit at the back
        drain;
        write_capacity(5'd0);
        send_key(32'h7fff_ffff, draw_wait(send_quiet));   // hit still moves to front
        send_key(32'h0000_0005, draw_wait(send_quiet));   // miss gives the error status
        drain;
        write_capacity(5'd2);
        send_key(32'h0000_0006, draw_wait(send_quiet));   // one eviction, occupancy kept
        send_key(32'h0000_0000, draw_wait(send_quiet));   // a miss at capacity, evicts again
        drain;
        write_capacity(5'd31);                            // saturates at the depth
        for (int i = 0; i < 12; i++)
            send_key(32'h0000_0100 + i, draw_wait(send_quiet));
        drain;
    endtask

    // one phase at a given capacity; keys come mostly from a pool seeded with
    // what is held now, so hits, misses and evictions all occur
    task automatic test_random_phase(input logic [CAP_W-1:0] cap, input int unsigned items);
        logic [KEY_W-1:0] pool [$];
        int unsigned      fresh;
        pool.delete();
        write_capacity(cap);
        for (int i = 0; i < held_count; i++)
            if ($urandom_range(0, 3) != 0)
                pool.push_back(held_keys[i]);
        fresh = 2 + $urandom_range(0, cap > DEPTH ? DEPTH : cap);
        for (int i = 0; i < fresh; i++)
            pool.push_back($urandom());
        for (int n = 0; n < items; n++) begin
            if ($urandom_range(0, 7) == 0)
                send_key($urandom(), draw_wait(send_quiet));
            else
                send_key(pool[$urandom_range(0, pool.size() - 1)], draw_wait(send_quiet));
        end
        drain;
    endtask

    // receiver holds off for a long stretch while the sender offers back to back
    task automatic test_backpressure;
        write_capacity(5'd8);
        hold_armed = 1'b1;
        for (int n = 0; n < 40; n++)
            send_key($urandom_range(0, 11), 0);
        drain;
    endtask

    initial begin : main_sequence
        logic [CAP_W-1:0] phase_caps [11];
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        i_valid         = 1'b0;
        i_key_value     = '0;
        hold_armed      = 1'b0;
        held_count      = 0;
        capacity_shadow = lvt_pkg::CAP_RESET;
        fault_count     = 0;
        cycle_count     = 0;
        send_quiet      = 0;
        for (int i = 0; i < DEPTH; i++)
            held_keys[i] = '0;
        phase_caps = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd31, 5'd2, 5'd17, 5'd8, 5'd3, 5'd16, 5'd0};
        phase_caps[10] = CAP_W'($urandom_range(0, 31));

        // synchronous reset
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed;
        for (int p = 0; p < 11; p++)
            test_random_phase(phase_caps[p], 50);
        test_backpressure;
        test_random_phase(5'd16, 30);

        drain;
        repeat (10) @(posedge i_clk);
        if (fault_count == 0 && pending_results.size() == 0) begin
            $display("PASS lru_value_tracker");
        end else begin
            $display("FAIL lru_value_tracker");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/lvt_pkg.sv
hdl/lvt_ctrl.sv
hdl/lvt_datapath.sv
hdl/lru_value_tracker.sv
bench/testbench.sv
